// ===== rtl/iso_datetime_text_parser_unit_defines.svh =====
// Assertion macros for the port checker file.
`ifndef ISO_DATETIME_TEXT_PARSER_UNIT_DEFINES_SVH
`define ISO_DATETIME_TEXT_PARSER_UNIT_DEFINES_SVH

// Check in the same cycle as the antecedent.
`define IDTP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check in the cycle after the antecedent.
`define IDTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/idtp_pkg.sv =====
package idtp_pkg;

    localparam logic [1:0] MODE_DATE     = 2'd0;
    localparam logic [1:0] MODE_TIME     = 2'd1;
    localparam logic [1:0] MODE_DATETIME = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } char_t;

    typedef struct packed {
        logic               valid_res;
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [19:0]        microsecond;
        logic               tz_present;
        logic signed [11:0] tz_offset;
    } result_t;

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // Weight of a fraction digit by its position, so the sum is already in microseconds.
    function automatic logic [19:0] frac_place(input logic [2:0] pos);
        logic [19:0] w;
        case (pos)
            3'd0:    w = 20'd100000;
            3'd1:    w = 20'd10000;
            3'd2:    w = 20'd1000;
            3'd3:    w = 20'd100;
            3'd4:    w = 20'd10;
            3'd5:    w = 20'd1;
            default: w = 20'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/iso_datetime_text_parser_unit.sv =====
// Parses ISO 8601 / RFC 3339 date, time or datetime text, one byte per transaction on the
// char channel; cfg_we writes format_mode (0 date, 1 time, 2 or 3 datetime with optional Z or
// +/-HH:MM offset); the user must write it only while no string is in flight and no result is
// pending, which the block does not enforce. Bytes are taken back to back while char_stall is
// low: the parse state and its small digit accumulators update at the accepting edge, and
// the byte flagged is_last loads the checked result into the output register, which drives
// result_valid in the next cycle, or into the skid register while the output is stalled. The
// skid register holds a second result while the first is stalled; char_stall rises only when
// both are full. All result fields are zero when valid_res is zero.
module iso_datetime_text_parser_unit
    import idtp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  char_t      char_data,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata
);

    typedef enum logic [4:0] {
        PH_START     = 5'd0,
        PH_YEAR      = 5'd1,
        PH_DASH1     = 5'd2,
        PH_MONTH     = 5'd3,
        PH_DASH2     = 5'd4,
        PH_DAY       = 5'd5,
        PH_DATE_END  = 5'd6,
        PH_HOUR      = 5'd7,
        PH_COLON     = 5'd8,
        PH_MINUTE    = 5'd9,
        PH_AFTER_MIN = 5'd10,
        PH_SECOND    = 5'd11,
        PH_AFTER_SEC = 5'd12,
        PH_FRAC      = 5'd13,
        PH_OFF_H     = 5'd14,
        PH_OFF_COLON = 5'd15,
        PH_OFF_M     = 5'd16,
        PH_DONE      = 5'd17
    } phase_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    function automatic logic [6:0] acc_step(input logic [6:0] a, input logic [3:0] d);
        return a * 7'd10 + {3'b000, d};
    endfunction

    logic [1:0]  mode_reg, mode_next;
    phase_t      phase_reg, phase_next, phase_w, phase_upd;
    logic [2:0]  cnt_reg, cnt_next, cnt_w, cnt_upd;
    logic        failed_reg, failed_next, failed_upd;
    logic [15:0] year_bcd_reg, year_bcd_next, year_bcd_upd;
    logic [6:0]  month_reg, month_next, month_upd;
    logic [6:0]  day_reg, day_next, day_upd;
    logic [6:0]  hour_reg, hour_next, hour_upd;
    logic [6:0]  minute_reg, minute_next, minute_upd;
    logic [6:0]  second_reg, second_next, second_upd;
    logic [19:0] frac_reg, frac_next, frac_upd;
    logic        off_sign_reg, off_sign_next, off_sign_upd;
    logic [6:0]  off_h_reg, off_h_next, off_h_upd;
    logic [6:0]  off_m_reg, off_m_next, off_m_upd;
    logic        off_seen_reg, off_seen_next, off_seen_upd;
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     out_data_reg, out_data_next;
    result_t     skid_data_reg, skid_data_next;

    logic        accept;
    logic        fire;
    logic [7:0]  ch;
    logic [3:0]  dig;
    logic        is_dig;
    logic        two_done;
    logic        after_req;
    logic        mode_dt;
    logic        is_date;
    logic        is_time;

    logic        fin_fail;
    logic        phase_ok;
    logic [6:0]  y_hi;
    logic [6:0]  y_lo;
    logic [13:0] year_bin;
    logic        leap;
    logic [4:0]  dmax;
    logic        date_ok;
    logic        time_ok;
    logic        off_ok;
    logic        ok;
    logic [10:0] off_mag;
    logic [11:0] off_val;
    result_t     res;

    assign accept     = char_valid && !char_stall;
    assign fire       = accept && char_data.is_last;
    assign char_stall = skid_valid_reg;
    assign ch         = char_data.char_code;
    assign dig        = ch[3:0];
    assign is_dig     = (ch inside {[CH_ZERO:CH_NINE]});
    assign mode_dt    = mode_reg[1];
    assign is_date    = (mode_reg != MODE_TIME);
    assign is_time    = (mode_reg != MODE_DATE);
    assign mode_next  = cfg_we ? cfg_wdata : mode_reg;

    // Byte consumption
    always_comb
    begin
        phase_upd    = phase_reg;
        cnt_upd      = cnt_reg;
        failed_upd   = failed_reg;
        year_bcd_upd = year_bcd_reg;
        month_upd    = month_reg;
        day_upd      = day_reg;
        hour_upd     = hour_reg;
        minute_upd   = minute_reg;
        second_upd   = second_reg;
        frac_upd     = frac_reg;
        off_sign_upd = off_sign_reg;
        off_h_upd    = off_h_reg;
        off_m_upd    = off_m_reg;
        off_seen_upd = off_seen_reg;
        after_req    = 1'b0;
        phase_w      = phase_reg;
        cnt_w        = cnt_reg;

        if (phase_reg == PH_START)
        begin
            phase_w = (mode_reg == MODE_TIME) ? PH_HOUR : PH_YEAR;
            cnt_w   = '0;
        end
        two_done = (cnt_w == 3'd1);

        if (accept && !failed_reg)
        begin
            phase_upd = phase_w;
            cnt_upd   = cnt_w;
            case (phase_w)
                PH_YEAR:
                begin
                    if (!is_dig)
                        failed_upd = 1'b1;
                    else
                    begin
                        year_bcd_upd = {year_bcd_reg[11:0], dig};
                        if (cnt_w == 3'd3)
                        begin
                            cnt_upd   = '0;
                            phase_upd = PH_DASH1;
                        end
                        else
                            cnt_upd = cnt_w + 3'd1;
                    end
                end
                PH_DASH1:
                begin
                    if (ch == CH_DASH) phase_upd = PH_MONTH;
                    else failed_upd = 1'b1;
                end
                PH_MONTH:
                begin
                    if (!is_dig)
                        failed_upd = 1'b1;
                    else
                    begin
                        month_upd = acc_step(month_reg, dig);
                        cnt_upd   = two_done ? 3'd0 : cnt_w + 3'd1;
                        if (two_done) phase_upd = PH_DASH2;
                    end
                end
                PH_DASH2:
                begin
                    if (ch == CH_DASH) phase_upd = PH_DAY;
                    else failed_upd = 1'b1;
                end
                PH_DAY:
                begin
                    if (!is_dig)
                        failed_upd = 1'b1;
                    else
                    begin
                        day_upd = acc_step(day_reg, dig);
                        cnt_upd = two_done ? 3'd0 : cnt_w + 3'd1;
                        if (two_done) phase_upd = PH_DATE_END;
                    end
                end
                PH_DATE_END:
                begin
                    if (mode_dt && (ch == CH_T || ch == CH_SPACE)) phase_upd = PH_HOUR;
                    else failed_upd = 1'b1;
                end
                PH_HOUR:
                begin
                    if (!is_dig)
                        failed_upd = 1'b1;
                    else
                    begin
                        hour_upd = acc_step(hour_reg, dig);
                        cnt_upd  = two_done ? 3'd0 : cnt_w + 3'd1;
                        if (two_done) phase_upd = PH_COLON;
                    end
                end
                PH_COLON:
                begin
                    if (ch == CH_COLON) phase_upd = PH_MINUTE;
                    else failed_upd = 1'b1;
                end
                PH_MINUTE:
                begin
                    if (!is_dig)
                        failed_upd = 1'b1;
                    else
                    begin
                        minute_upd = acc_step(minute_reg, dig);
                        cnt_upd    = two_done ? 3'd0 : cnt_w + 3'd1;
                        if (two_done) phase_upd = PH_AFTER_MIN;
                    end
                end
                PH_AFTER_MIN:
                begin
                    if (ch == CH_COLON)
                        phase_upd = PH_SECOND;
                    else if (ch == CH_DOT)
                    begin
                        cnt_upd   = '0;
                        phase_upd = PH_FRAC;
                    end
                    else
                        after_req = 1'b1;
                end
                PH_SECOND:
                begin
                    if (!is_dig)
                        failed_upd = 1'b1;
                    else
                    begin
                        second_upd = acc_step(second_reg, dig);
                        cnt_upd    = two_done ? 3'd0 : cnt_w + 3'd1;
                        if (two_done) phase_upd = PH_AFTER_SEC;
                    end
                end
                PH_AFTER_SEC:
                begin
                    if (ch == CH_DOT)
                    begin
                        cnt_upd   = '0;
                        phase_upd = PH_FRAC;
                    end
                    else
                        after_req = 1'b1;
                end
                PH_FRAC:
                begin
                    if (is_dig)
                    begin
                        if (cnt_w >= 3'd6)
                            failed_upd = 1'b1;
                        else
                        begin
                            frac_upd = frac_reg + 20'(dig) * frac_place(cnt_w);
                            cnt_upd  = cnt_w + 3'd1;
                        end
                    end
                    else if (cnt_w == 3'd0)
                        failed_upd = 1'b1;
                    else
                    begin
                        cnt_upd   = '0;
                        after_req = 1'b1;
                    end
                end
                PH_OFF_H:
                begin
                    if (!is_dig)
                        failed_upd = 1'b1;
                    else
                    begin
                        off_h_upd = acc_step(off_h_reg, dig);
                        cnt_upd   = two_done ? 3'd0 : cnt_w + 3'd1;
                        if (two_done) phase_upd = PH_OFF_COLON;
                    end
                end
                PH_OFF_COLON:
                begin
                    if (ch == CH_COLON) phase_upd = PH_OFF_M;
                    else failed_upd = 1'b1;
                end
                PH_OFF_M:
                begin
                    if (!is_dig)
                        failed_upd = 1'b1;
                    else
                    begin
                        off_m_upd = acc_step(off_m_reg, dig);
                        cnt_upd   = two_done ? 3'd0 : cnt_w + 3'd1;
                        if (two_done)
                        begin
                            phase_upd    = PH_DONE;
                            off_seen_upd = 1'b1;
                        end
                    end
                end
                default: failed_upd = 1'b1;
            endcase

            // Zone designator or numeric offset after the time
            if (after_req)
            begin
                if (!mode_dt)
                    failed_upd = 1'b1;
                else if (ch == CH_Z)
                begin
                    off_seen_upd = 1'b1;
                    phase_upd    = PH_DONE;
                end
                else if (ch == CH_PLUS || ch == CH_DASH)
                begin
                    off_sign_upd = (ch == CH_DASH);
                    cnt_upd      = '0;
                    phase_upd    = PH_OFF_H;
                end
                else
                    failed_upd = 1'b1;
            end
        end
    end

    // Final checks and result fields
    always_comb
    begin
        fin_fail = failed_upd || (phase_upd == PH_FRAC && cnt_upd == 3'd0);
        case (phase_upd)
            PH_DATE_END:                         phase_ok = (mode_reg == MODE_DATE);
            PH_AFTER_MIN, PH_AFTER_SEC, PH_FRAC: phase_ok = is_time;
            PH_DONE:                             phase_ok = mode_dt;
            default:                             phase_ok = 1'b0;
        endcase

        y_hi     = 7'(year_bcd_upd[15:12]) * 7'd10 + 7'(year_bcd_upd[11:8]);
        y_lo     = 7'(year_bcd_upd[7:4]) * 7'd10 + 7'(year_bcd_upd[3:0]);
        year_bin = 14'(y_hi) * 14'd100 + 14'(y_lo);
        leap     = (y_lo != 7'd0) ? (y_lo[1:0] == 2'b00) : (y_hi[1:0] == 2'b00);
        dmax     = month_days(month_upd[3:0]) + 5'((month_upd == 7'd2) && leap);
        date_ok  = (year_bcd_upd != 16'd0) && (month_upd >= 7'd1) && (month_upd <= 7'd12)
                   && (day_upd >= 7'd1) && (day_upd <= 7'(dmax));
        time_ok  = (hour_upd < 7'd24) && (minute_upd < 7'd60) && (second_upd < 7'd60);
        off_ok   = !off_seen_upd || ((off_h_upd <= 7'd23) && (off_m_upd <= 7'd59));
        ok       = !fin_fail && phase_ok && (!is_date || date_ok) && (!is_time || time_ok)
                   && off_ok;

        off_mag  = 11'(off_h_upd) * 11'd60 + 11'(off_m_upd);
        off_val  = off_sign_upd ? (12'd0 - {1'b0, off_mag}) : {1'b0, off_mag};

        res = '0;
        if (ok)
        begin
            res.valid_res = 1'b1;
            if (is_date)
            begin
                res.year  = year_bin;
                res.month = month_upd[3:0];
                res.day   = day_upd[4:0];
            end
            if (is_time)
            begin
                res.hour        = hour_upd[4:0];
                res.minute      = minute_upd[5:0];
                res.second      = second_upd[5:0];
                res.microsecond = frac_upd;
            end
            if (off_seen_upd && mode_dt)
            begin
                res.tz_present = 1'b1;
                res.tz_offset  = $signed(off_val);
            end
        end
    end

    // Clear the parse state after the last byte
    always_comb
    begin
        if (fire)
        begin
            phase_next    = PH_START;
            cnt_next      = '0;
            failed_next   = 1'b0;
            year_bcd_next = '0;
            month_next    = '0;
            day_next      = '0;
            hour_next     = '0;
            minute_next   = '0;
            second_next   = '0;
            frac_next     = '0;
            off_sign_next = 1'b0;
            off_h_next    = '0;
            off_m_next    = '0;
            off_seen_next = 1'b0;
        end
        else
        begin
            phase_next    = phase_upd;
            cnt_next      = cnt_upd;
            failed_next   = failed_upd;
            year_bcd_next = year_bcd_upd;
            month_next    = month_upd;
            day_next      = day_upd;
            hour_next     = hour_upd;
            minute_next   = minute_upd;
            second_next   = second_upd;
            frac_next     = frac_upd;
            off_sign_next = off_sign_upd;
            off_h_next    = off_h_upd;
            off_m_next    = off_m_upd;
            off_seen_next = off_seen_upd;
        end
    end

    // Output register with skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !result_stall)
        begin
            out_valid_next  = skid_valid_reg || fire;
            out_data_next   = skid_valid_reg ? skid_data_reg : res;
            skid_valid_next = 1'b0;
        end
        else if (fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_DATE;
            phase_reg      <= PH_START;
            cnt_reg        <= '0;
            failed_reg     <= 1'b0;
            year_bcd_reg   <= '0;
            month_reg      <= '0;
            day_reg        <= '0;
            hour_reg       <= '0;
            minute_reg     <= '0;
            second_reg     <= '0;
            frac_reg       <= '0;
            off_sign_reg   <= 1'b0;
            off_h_reg      <= '0;
            off_m_reg      <= '0;
            off_seen_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            failed_reg     <= failed_next;
            year_bcd_reg   <= year_bcd_next;
            month_reg      <= month_next;
            day_reg        <= day_next;
            hour_reg       <= hour_next;
            minute_reg     <= minute_next;
            second_reg     <= second_next;
            frac_reg       <= frac_next;
            off_sign_reg   <= off_sign_next;
            off_h_reg      <= off_h_next;
            off_m_reg      <= off_m_next;
            off_seen_reg   <= off_seen_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/idtp_port_checker.sv =====
`include "iso_datetime_text_parser_unit_defines.svh"

module idtp_port_checker
    import idtp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    char_valid,
    input logic    char_stall,
    input char_t   char_data,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result_data
);

    `IDTP_ASSERT_SAME(a_invalid_zero, result_valid && !result_data.valid_res, result_data == '0, "invalid result carries nonzero fields")
    `IDTP_ASSERT_SAME(a_valid_ranges, result_valid && result_data.valid_res, result_data.month <= 4'd12 && result_data.day <= 5'd31 && result_data.hour <= 5'd23 && result_data.minute <= 6'd59 && result_data.second <= 6'd59 && result_data.microsecond <= 20'd999999, "valid result field out of range")
    `IDTP_ASSERT_SAME(a_no_offset_zero, result_valid && !result_data.tz_present, result_data.tz_offset == 12'sd0, "offset minutes without offset")
    `IDTP_ASSERT_NEXT(a_last_gives_result, char_valid && !char_stall && char_data.is_last, result_valid, "last byte accepted but no result follows")
    `IDTP_ASSERT_NEXT(a_stalled_result_holds, result_valid && result_stall, result_valid && $stable(result_data), "stalled result transaction changed")

endmodule

bind iso_datetime_text_parser_unit idtp_port_checker u_idtp_port_checker (.*);

// ===== sim/testbench.sv =====
module testbench
    import idtp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  MODE_DATETIME_ALT = 2'd3;
    localparam int unsigned CYCLE_LIMIT       = 400000;
    localparam int          SETTLE_CYCLES     = 4;

    typedef enum logic [4:0] {
        ST_START, ST_YEAR, ST_DASH1, ST_MONTH, ST_DASH2, ST_DAY, ST_DATE_END,
        ST_HOUR, ST_COLON, ST_MINUTE, ST_AFTER_MIN, ST_SECOND, ST_AFTER_SEC,
        ST_FRAC, ST_OFF_H, ST_OFF_COLON, ST_OFF_M, ST_DONE
    } parse_phase_e;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       char_valid   = 1'b0;
    logic       char_stall;
    char_t      char_data    = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    result_t    result_data;
    logic       cfg_we       = 1'b0;
    logic [1:0] cfg_wdata    = MODE_DATE;

    // parser shadow state
    logic [1:0]   parser_mode = MODE_DATE;
    parse_phase_e phase;
    logic [2:0]   digit_cnt;
    logic         failed_flag;
    logic [13:0]  year_sum;
    logic [13:0]  month_sum;
    logic [13:0]  day_sum;
    logic [13:0]  hour_sum;
    logic [13:0]  minute_sum;
    logic [13:0]  second_sum;
    logic [19:0]  frac_sum;
    logic         off_minus;
    logic [13:0]  off_hour_sum;
    logic [13:0]  off_min_sum;
    logic         off_present;

    result_t     expected_stamps[$];
    char_t       pending_chars[$];
    logic [7:0]  text_buf[$];

    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned bytes_queued   = 0;
    int unsigned bytes_sent     = 0;
    int unsigned strings_queued = 0;
    int unsigned results_seen   = 0;
    int unsigned results_valid  = 0;
    int unsigned char_gap       = 0;
    int unsigned sink_wait      = 0;
    bit          sender_gapless = 1'b0;
    bit          sink_gapless   = 1'b0;

    iso_datetime_text_parser_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("iso_datetime_text_parser_unit regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic bit is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    task automatic clear_parser();
        phase        = ST_START;
        digit_cnt    = '0;
        failed_flag  = 1'b0;
        year_sum     = '0;
        month_sum    = '0;
        day_sum      = '0;
        hour_sum     = '0;
        minute_sum   = '0;
        second_sum   = '0;
        frac_sum     = '0;
        off_minus    = 1'b0;
        off_hour_sum = '0;
        off_min_sum  = '0;
        off_present  = 1'b0;
    endtask

    task automatic take_digit(input logic [7:0] c, inout logic [13:0] acc,
                              input int need, input parse_phase_e nxt);
        if (!is_digit(c))
            failed_flag = 1'b1;
        else
        begin
            acc = 14'(acc * 10 + (c - "0"));
            digit_cnt++;
            if (digit_cnt >= need)
            begin
                digit_cnt = '0;
                phase = nxt;
            end
        end
    endtask

    task automatic pad_fraction();
        if (digit_cnt != 0)
            repeat (6 - digit_cnt) frac_sum = 20'(frac_sum * 10);
        digit_cnt = '0;
    endtask

    task automatic take_zone(input logic [7:0] c);
        if (parser_mode < MODE_DATETIME)
            failed_flag = 1'b1;
        else if (c == "Z")
        begin
            off_present = 1'b1;
            phase = ST_DONE;
        end
        else if (c == "+" || c == "-")
        begin
            off_minus = (c == "-");
            digit_cnt = '0;
            phase = ST_OFF_H;
        end
        else
            failed_flag = 1'b1;
    endtask

    task automatic consume_char(input logic [7:0] c);
        if (phase == ST_START)
        begin
            if (parser_mode == MODE_TIME)
                phase = ST_HOUR;
            else
                phase = ST_YEAR;
            digit_cnt = '0;
        end
        case (phase)
            ST_YEAR:      take_digit(c, year_sum, 4, ST_DASH1);
            ST_DASH1:     if (c == "-") phase = ST_MONTH; else failed_flag = 1'b1;
            ST_MONTH:     take_digit(c, month_sum, 2, ST_DASH2);
            ST_DASH2:     if (c == "-") phase = ST_DAY; else failed_flag = 1'b1;
            ST_DAY:       take_digit(c, day_sum, 2, ST_DATE_END);
            ST_DATE_END:
                if (parser_mode >= MODE_DATETIME && (c == "T" || c == " "))
                    phase = ST_HOUR;
                else
                    failed_flag = 1'b1;
            ST_HOUR:      take_digit(c, hour_sum, 2, ST_COLON);
            ST_COLON:     if (c == ":") phase = ST_MINUTE; else failed_flag = 1'b1;
            ST_MINUTE:    take_digit(c, minute_sum, 2, ST_AFTER_MIN);
            ST_AFTER_MIN:
                if (c == ":")
                    phase = ST_SECOND;
                else if (c == ".")
                begin
                    digit_cnt = '0;
                    phase = ST_FRAC;
                end
                else
                    take_zone(c);
            ST_SECOND:    take_digit(c, second_sum, 2, ST_AFTER_SEC);
            ST_AFTER_SEC:
                if (c == ".")
                begin
                    digit_cnt = '0;
                    phase = ST_FRAC;
                end
                else
                    take_zone(c);
            ST_FRAC:
                if (is_digit(c))
                begin
                    if (digit_cnt >= 6)
                        failed_flag = 1'b1;
                    else
                    begin
                        frac_sum = 20'(frac_sum * 10 + (c - "0"));
                        digit_cnt++;
                    end
                end
                else if (digit_cnt == 0)
                    failed_flag = 1'b1;
                else
                begin
                    pad_fraction();
                    take_zone(c);
                end
            ST_OFF_H:     take_digit(c, off_hour_sum, 2, ST_OFF_COLON);
            ST_OFF_COLON: if (c == ":") phase = ST_OFF_M; else failed_flag = 1'b1;
            ST_OFF_M:
            begin
                take_digit(c, off_min_sum, 2, ST_DONE);
                if (phase == ST_DONE)
                    off_present = 1'b1;
            end
            default:      failed_flag = 1'b1;
        endcase
    endtask

    function automatic bit date_in_range();
        logic [4:0] last_day;
        bit         leap;
        if (year_sum < 1 || year_sum > 9999 || month_sum < 1 || month_sum > 12)
            return 1'b0;
        leap = (year_sum % 4 == 0) && ((year_sum % 100 != 0) || (year_sum % 400 == 0));
        case (month_sum)
            14'd2:                        last_day = leap ? 5'd29 : 5'd28;
            14'd4, 14'd6, 14'd9, 14'd11:  last_day = 5'd30;
            default:                      last_day = 5'd31;
        endcase
        return (day_sum >= 1) && (day_sum <= last_day);
    endfunction

    task automatic parse_step(input char_t ch);
        result_t     stamp;
        bit          ok;
        bit          has_date;
        bit          has_time;
        logic [11:0] mag;
        if (!failed_flag)
            consume_char(ch.char_code);
        if (ch.is_last)
        begin
            if (!failed_flag && phase == ST_FRAC)
            begin
                if (digit_cnt == 0)
                    failed_flag = 1'b1;
                else
                    pad_fraction();
            end
            has_date = (parser_mode != MODE_TIME);
            has_time = (parser_mode != MODE_DATE);
            ok = !failed_flag;
            if (ok)
            begin
                if (phase == ST_DATE_END)
                    ok = (parser_mode == MODE_DATE);
                else if (phase == ST_AFTER_MIN || phase == ST_AFTER_SEC || phase == ST_FRAC)
                    ok = has_time;
                else
                    ok = (phase == ST_DONE) && (parser_mode >= MODE_DATETIME);
            end
            if (ok && has_date)
                ok = date_in_range();
            if (ok && has_time)
                ok = hour_sum < 24 && minute_sum < 60 && second_sum < 60 && frac_sum < 1000000;
            if (ok && off_present)
                ok = off_hour_sum <= 23 && off_min_sum <= 59;
            stamp = '0;
            if (ok)
            begin
                stamp.valid_res = 1'b1;
                if (has_date)
                begin
                    stamp.year  = year_sum;
                    stamp.month = month_sum[3:0];
                    stamp.day   = day_sum[4:0];
                end
                if (has_time)
                begin
                    stamp.hour        = hour_sum[4:0];
                    stamp.minute      = minute_sum[5:0];
                    stamp.second      = second_sum[5:0];
                    stamp.microsecond = frac_sum;
                end
                if (off_present && parser_mode >= MODE_DATETIME)
                begin
                    mag = 12'(off_hour_sum * 60 + off_min_sum);
                    stamp.tz_present = 1'b1;
                    stamp.tz_offset  = off_minus ? -mag : mag;
                end
            end
            expected_stamps.push_back(stamp);
            clear_parser();
        end
    endtask

    task automatic compare_field(input string name, input logic [19:0] got,
                                 input logic [19:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
    endtask

    task automatic check_stamp(input result_t got);
        result_t want;
        results_seen++;
        if (expected_stamps.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with no string pending: %h",
                                      results_seen, got));
            return;
        end
        want = expected_stamps.pop_front();
        if (want.valid_res)
            results_valid++;
        compare_field("valid_res", 20'(got.valid_res), 20'(want.valid_res));
        compare_field("year", 20'(got.year), 20'(want.year));
        compare_field("month", 20'(got.month), 20'(want.month));
        compare_field("day", 20'(got.day), 20'(want.day));
        compare_field("hour", 20'(got.hour), 20'(want.hour));
        compare_field("minute", 20'(got.minute), 20'(want.minute));
        compare_field("second", 20'(got.second), 20'(want.second));
        compare_field("microsecond", got.microsecond, want.microsecond);
        compare_field("tz_present", 20'(got.tz_present), 20'(want.tz_present));
        compare_field("tz_offset", 20'(got.tz_offset), 20'(want.tz_offset));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : char_driver
        int unsigned wait_left;
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_data  <= '0;
            char_gap   <= 0;
        end
        else
        begin
            wait_left = char_gap;
            if (char_valid && !char_stall)
            begin
                parse_step(char_data);
                bytes_sent++;
                wait_left = sender_gapless ? 0 : $urandom_range(0, 6);
            end
            // hold the payload while stalled
            if (!(char_valid && char_stall))
            begin
                if (wait_left != 0)
                begin
                    char_valid <= 1'b0;
                    char_gap   <= wait_left - 1;
                end
                else if (pending_chars.size() != 0)
                begin
                    char_data  <= pending_chars.pop_front();
                    char_valid <= 1'b1;
                    char_gap   <= 0;
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        int unsigned hold_left;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            sink_wait    <= 0;
        end
        else
        begin
            hold_left = sink_wait;
            if (result_valid && !result_stall)
            begin
                check_stamp(result_data);
                hold_left = sink_gapless ? 0 : $urandom_range(0, 6);
            end
            else if (hold_left != 0)
                hold_left--;
            sink_wait    <= hold_left;
            result_stall <= (hold_left != 0);
        end
    end

    task automatic wait_idle();
        while (bytes_sent != bytes_queued || expected_stamps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        parser_mode = mode;
    endtask

    function automatic logic [7:0] random_char();
        string charset;
        charset = "0123456789-:T .Z+";
        if ($urandom_range(0, 1) == 0)
            return charset[$urandom_range(0, charset.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic add_number(input int value, input int width);
        int div;
        div = 1;
        repeat (width - 1) div *= 10;
        while (div != 0)
        begin
            text_buf.push_back(8'("0" + (value / div) % 10));
            div /= 10;
        end
    endtask

    task automatic emit_text();
        char_t ch;
        int    i;
        for (i = 0; i < text_buf.size(); i++)
        begin
            ch.char_code = text_buf[i];
            ch.is_last   = (i == text_buf.size() - 1);
            pending_chars.push_back(ch);
        end
        bytes_queued += text_buf.size();
        strings_queued++;
        text_buf.delete();
    endtask

    task automatic queue_text(input string s);
        add_text(s);
        emit_text();
    endtask

    task automatic add_date();
        int y;
        int m;
        int d;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            y = $urandom_range(0, 24) * 400;
        else if (r == 1)
            y = $urandom_range(1, 99) * 100;
        else if (r == 2)
            y = $urandom_range(0, 2499) * 4;
        else if (r == 3)
            y = $urandom_range(0, 1) ? 0 : 9999;
        else
            y = $urandom_range(1, 9999);
        r = $urandom_range(0, 9);
        if (r < 2)
            m = 2;
        else if (r < 9)
            m = $urandom_range(1, 12);
        else
            m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
        r = $urandom_range(0, 9);
        if (r < 6)
            d = $urandom_range(1, 28);
        else if (r < 9)
            d = $urandom_range(29, 31);
        else
            d = $urandom_range(0, 1) ? 0 : $urandom_range(32, 99);
        add_number(y, 4);
        add_text("-");
        add_number(m, 2);
        add_text("-");
        add_number(d, 2);
    endtask

    task automatic add_time();
        int n;
        add_number(($urandom_range(0, 9) < 9) ? $urandom_range(0, 23)
                                              : $urandom_range(24, 99), 2);
        add_text(":");
        add_number(($urandom_range(0, 9) < 9) ? $urandom_range(0, 59)
                                              : $urandom_range(60, 99), 2);
        if ($urandom_range(0, 4) < 3)
        begin
            add_text(":");
            add_number(($urandom_range(0, 9) < 9) ? $urandom_range(0, 59)
                                                  : $urandom_range(60, 99), 2);
        end
        if ($urandom_range(0, 4) < 2)
        begin
            n = ($urandom_range(0, 11) == 0) ? 7 : $urandom_range(1, 6);
            add_text(".");
            repeat (n) add_number($urandom_range(0, 9), 1);
        end
    endtask

    task automatic add_zone();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return;
        if (r < 5)
        begin
            add_text("Z");
            return;
        end
        add_text($urandom_range(0, 1) ? "+" : "-");
        add_number(($urandom_range(0, 9) < 9) ? $urandom_range(0, 23)
                                              : $urandom_range(24, 99), 2);
        add_text(":");
        add_number(($urandom_range(0, 9) < 9) ? $urandom_range(0, 59)
                                              : $urandom_range(60, 99), 2);
    endtask

    task automatic mangle_text();
        int pos;
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 2))
            0: text_buf[pos] = random_char();
            1: while (text_buf.size() > pos + 1) void'(text_buf.pop_back());
            default: text_buf.insert(pos, random_char());
        endcase
    endtask

    task automatic random_phase(input logic [1:0] mode, input int budget);
        int unsigned start_bytes;
        bit          paused;
        int          pick;
        int          kind;
        write_mode(mode);
        start_bytes    = bytes_queued;
        paused         = 1'b0;
        sender_gapless = ($urandom_range(0, 3) == 0);
        sink_gapless   = ($urandom_range(0, 3) == 0);
        while (bytes_queued - start_bytes < budget)
        begin
            // drain everything in flight before the second half
            if (!paused && bytes_queued - start_bytes >= budget / 2)
            begin
                paused = 1'b1;
                wait_idle();
                sender_gapless = ($urandom_range(0, 3) == 0);
                sink_gapless   = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 9);
            if (pick < 2)
                repeat ($urandom_range(1, 16)) text_buf.push_back(random_char());
            else
            begin
                kind = (mode > MODE_DATETIME) ? MODE_DATETIME : mode;
                if ($urandom_range(0, 9) == 0)
                    kind = $urandom_range(MODE_DATE, MODE_DATETIME);
                if (kind == MODE_DATE)
                    add_date();
                else if (kind == MODE_TIME)
                    add_time();
                else
                begin
                    add_date();
                    add_text($urandom_range(0, 1) ? "T" : " ");
                    add_time();
                    add_zone();
                end
                if (pick == 2 || $urandom_range(0, 7) == 0)
                    mangle_text();
            end
            emit_text();
        end
    endtask

    initial
    begin
        clear_parser();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_mode(MODE_DATE);
        queue_text("2024-02-29");
        queue_text("1900-02-29");
        queue_text("2000-02-29");
        queue_text("0000-01-01");
        queue_text("9999-12-31");
        queue_text("2023-13-01");
        queue_text("2023-04-31");
        queue_text("2023-01-01T");
        text_buf.push_back(8'h00);
        emit_text();

        write_mode(MODE_TIME);
        queue_text("23:59:59.999999");
        queue_text("00:00");
        queue_text("12:30.5");
        queue_text("24:00");
        queue_text("12:30:60");
        queue_text("12:30:00.1234567");
        queue_text("12:30:00.");
        queue_text("12:30Z");

        write_mode(MODE_DATETIME);
        queue_text("2024-02-29T23:59:59.123456+23:59");
        queue_text("1970-01-01 00:00:00Z");
        queue_text("2024-01-01T00:00-05:30");
        queue_text("2024-01-01T00:00+24:00");
        queue_text("2024-01-01T00:00-00:60");
        queue_text("2024-01-01");
        add_text("2024-01-01");
        text_buf.push_back(8'hFF);
        emit_text();

        write_mode(MODE_DATETIME_ALT);
        queue_text("1999-12-31T23:59:60");
        queue_text("0001-01-01T00:00:00.000001-23:59");

        random_phase(MODE_DATETIME, 40);
        random_phase(MODE_DATE, 40);
        random_phase(MODE_TIME, 40);
        random_phase(MODE_DATETIME_ALT, 40);
        random_phase(MODE_DATETIME, 40);
        random_phase(MODE_TIME, 40);
        random_phase(MODE_DATE, 40);
        random_phase(MODE_DATETIME, 40);

        wait_idle();
        if (expected_stamps.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_stamps.size()));

        $display("Run covered %0d strings (%0d bytes) across date, time and both datetime modes.",
                 strings_queued, bytes_sent);
        $display("%0d results compared, %0d of them valid timestamps, %0d mismatches.",
                 results_seen, results_valid, error_count);
        if (error_count == 0)
            $display("iso_datetime_text_parser_unit regression: pass");
        else
            $display("iso_datetime_text_parser_unit regression: fail");
        $finish;
    end

endmodule
